// ===== design/asfp_pkg.sv =====
// Package: parse phases, widths and a helper function for the data packet parser.
package asfp_pkg;

  localparam logic [15:0] PacketSizeReset = 16'd4096;

  typedef enum logic [4:0] {
    PH_ECC, PH_ECC_SKIP, PH_FLAGS, PH_SEGTYPE, PH_PLEN, PH_SEQ, PH_PAD,
    PH_TIME, PH_DUR, PH_COUNT, PH_STREAM, PH_OBJ, PH_OFFS, PH_RLEN,
    PH_REP_SKIP, PH_REP_SIZE, PH_REP_TIME, PH_LEN, PH_DATA, PH_GLEN,
    PH_GDATA, PH_TAIL
  } phase_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [6:0]  stream_number;
    logic        keyframe;
    logic [31:0] object_number;
    logic [31:0] fragment_offset;
    logic [31:0] presentation_time;
    logic [15:0] duration;
    logic        grouped;
    logic        first_byte;
    logic        last_byte;
    logic        length_error;
  } result_t;

  function automatic logic [2:0] code_width(input logic [1:0] code);
    return (code == 2'd3) ? 3'd4 : {1'b0, code};
  endfunction

endpackage

// ===== design/asfp_parse_core.sv =====
// Byte parser core: phase state machine and field registers, one byte per cycle.
module asfp_parse_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data,
  input  logic                    byte_valid,
  input  logic [7:0]              byte_data,
  output logic                    res_valid,
  output asfp_pkg::result_t       res
);

  asfp_pkg::phase_t ph_r, ph_nxt;
  logic [15:0] psize_r, psize_nxt, cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  fleft_r, fleft_nxt;
  logic [7:0]  lflags_r, lflags_nxt, segt_r, segt_nxt, stream_r, stream_nxt;
  logic [7:0]  gleft_r, gleft_nxt;
  logic [1:0]  stype_r, stype_nxt;
  logic [5:0]  segs_r, segs_nxt;
  logic [31:0] plen_r, plen_nxt, pad_r, pad_nxt, obj_r, obj_nxt, ofs_r, ofs_nxt;
  logic [31:0] rlen_r, rlen_nxt, rtime_r, rtime_nxt, skip_r, skip_nxt;
  logic [31:0] pleft_r, pleft_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic        firstp_r, firstp_nxt, gerr_r, gerr_nxt, cerr_r, cerr_nxt;
  logic        rv_nxt;
  asfp_pkg::result_t res_nxt;

  function automatic logic [2:0] fwidth(input asfp_pkg::phase_t p, input logic [7:0] lf,
                                         input logic [7:0] st, input logic [1:0] sz);
    case (p)
      asfp_pkg::PH_PLEN: return asfp_pkg::code_width(lf[6:5]);
      asfp_pkg::PH_SEQ:  return asfp_pkg::code_width(lf[2:1]);
      asfp_pkg::PH_PAD:  return asfp_pkg::code_width(lf[4:3]);
      asfp_pkg::PH_DUR:  return 3'd2;
      asfp_pkg::PH_OBJ:  return asfp_pkg::code_width(st[5:4]);
      asfp_pkg::PH_OFFS: return asfp_pkg::code_width(st[3:2]);
      asfp_pkg::PH_RLEN: return asfp_pkg::code_width(st[1:0]);
      asfp_pkg::PH_LEN:  return asfp_pkg::code_width(sz);
      default:           return 3'd4;
    endcase
  endfunction

  always_comb begin
    logic [15:0] rem16;
    logic signed [33:0] len;
    logic [2:0]  w, idx;
    logic [31:0] v;
    logic [8:0]  b1;
    logic        err, last, grp, go_len, go_obj, go_offs, go_rlen, go_rep, go_endseg;
    logic        go_seq, go_pad, go_afterpad, go_begin, go_aftergrp;
    ph_nxt = ph_r; psize_nxt = cfg_wr_en ? cfg_wr_data : psize_r;
    cnt_nxt = cnt_r; acc_nxt = acc_r; fleft_nxt = fleft_r; lflags_nxt = lflags_r;
    segt_nxt = segt_r; stream_nxt = stream_r; gleft_nxt = gleft_r; stype_nxt = stype_r;
    segs_nxt = segs_r; plen_nxt = plen_r; pad_nxt = pad_r; obj_nxt = obj_r;
    ofs_nxt = ofs_r; rlen_nxt = rlen_r; rtime_nxt = rtime_r; skip_nxt = skip_r;
    pleft_nxt = pleft_r; dur_nxt = dur_r; firstp_nxt = firstp_r; gerr_nxt = gerr_r;
    cerr_nxt = cerr_r; rv_nxt = 1'b0; res_nxt = res;
    rem16 = '0; len = '0; w = '0; idx = '0; v = '0; b1 = '0; err = 1'b0; last = 1'b0;
    grp = 1'b0; go_len = 1'b0; go_obj = 1'b0; go_offs = 1'b0; go_rlen = 1'b0;
    go_rep = 1'b0; go_endseg = 1'b0; go_seq = 1'b0; go_pad = 1'b0; go_afterpad = 1'b0;
    go_begin = 1'b0; go_aftergrp = 1'b0;
    if (byte_valid) begin
      cnt_nxt = cnt_r + 16'd1;
      rem16 = (psize_r > cnt_nxt) ? psize_r - cnt_nxt : 16'd0;
      unique case (ph_r)
        asfp_pkg::PH_ECC: begin
          stype_nxt = 2'd2; segs_nxt = 6'd1; skip_nxt = {28'd0, byte_data[3:0]};
          ph_nxt = (byte_data[3:0] != 4'd0) ? asfp_pkg::PH_ECC_SKIP : asfp_pkg::PH_FLAGS;
        end
        asfp_pkg::PH_ECC_SKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_nxt == 32'd0) ph_nxt = asfp_pkg::PH_FLAGS;
        end
        asfp_pkg::PH_FLAGS: begin
          lflags_nxt = byte_data; ph_nxt = asfp_pkg::PH_SEGTYPE;
        end
        asfp_pkg::PH_SEGTYPE: begin
          segt_nxt = byte_data;
          if (lflags_r[6:5] != 2'd0) begin
            ph_nxt = asfp_pkg::PH_PLEN; fleft_nxt = asfp_pkg::code_width(lflags_r[6:5]);
            acc_nxt = '0;
          end else begin
            plen_nxt = '0; go_seq = 1'b1;
          end
        end
        asfp_pkg::PH_COUNT: begin
          stype_nxt = byte_data[7:6]; segs_nxt = byte_data[5:0];
          ph_nxt = (byte_data[5:0] != 6'd0) ? asfp_pkg::PH_STREAM : asfp_pkg::PH_TAIL;
        end
        asfp_pkg::PH_STREAM: begin
          stream_nxt = byte_data; go_obj = 1'b1;
        end
        asfp_pkg::PH_REP_SIZE: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_nxt == 32'd0) begin
            ph_nxt = asfp_pkg::PH_REP_TIME; fleft_nxt = 3'd4; acc_nxt = '0;
          end
        end
        asfp_pkg::PH_REP_SKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_nxt == 32'd0) go_len = 1'b1;
        end
        asfp_pkg::PH_GLEN: begin
          b1 = {1'b0, byte_data} + 9'd1;
          pleft_nxt = ({23'd0, b1} >= pleft_r) ? 32'd0 : pleft_r - {23'd0, b1};
          cerr_nxt = gerr_r; gleft_nxt = byte_data; firstp_nxt = 1'b1;
          if ({8'd0, byte_data} > rem16) begin
            gleft_nxt = rem16[7:0]; cerr_nxt = 1'b1;
          end
          if (gleft_nxt == 8'd0) begin
            obj_nxt = obj_r + 32'd1; go_aftergrp = 1'b1;
          end else ph_nxt = asfp_pkg::PH_GDATA;
        end
        asfp_pkg::PH_DATA, asfp_pkg::PH_GDATA: begin
          grp = (ph_r == asfp_pkg::PH_GDATA);
          if (grp) begin
            gleft_nxt = gleft_r - 8'd1; last = (gleft_nxt == 8'd0);
          end else begin
            pleft_nxt = pleft_r - 32'd1; last = (pleft_nxt == 32'd0);
          end
          rv_nxt = 1'b1;
          res_nxt.payload_byte = byte_data;
          res_nxt.stream_number = stream_r[6:0];
          res_nxt.keyframe = stream_r[7];
          res_nxt.object_number = obj_r;
          res_nxt.fragment_offset = grp ? 32'd0 : ofs_r;
          res_nxt.presentation_time = grp ? ofs_r : rtime_r;
          res_nxt.duration = dur_r;
          res_nxt.grouped = grp;
          res_nxt.first_byte = firstp_r;
          res_nxt.last_byte = last;
          res_nxt.length_error = cerr_r;
          firstp_nxt = 1'b0;
          if (last) begin
            if (grp) begin
              obj_nxt = obj_r + 32'd1; go_aftergrp = 1'b1;
            end else go_endseg = 1'b1;
          end
        end
        asfp_pkg::PH_TAIL: begin
        end
        default: begin
          w = fwidth(ph_r, lflags_r, segt_r, stype_r);
          idx = (w - fleft_r) & 3'd3;
          v = acc_r | ({24'd0, byte_data} << {idx[1:0], 3'b000});
          acc_nxt = v;
          fleft_nxt = fleft_r - 3'd1;
          if (fleft_nxt == 3'd0) begin
            case (ph_r)
              asfp_pkg::PH_PLEN: begin plen_nxt = v; go_seq = 1'b1; end
              asfp_pkg::PH_SEQ:  go_pad = 1'b1;
              asfp_pkg::PH_PAD:  begin pad_nxt = v; go_afterpad = 1'b1; end
              asfp_pkg::PH_TIME: begin
                ph_nxt = asfp_pkg::PH_DUR; fleft_nxt = 3'd2; acc_nxt = '0;
              end
              asfp_pkg::PH_DUR: begin
                dur_nxt = v[15:0];
                if (lflags_r[0]) ph_nxt = asfp_pkg::PH_COUNT;
                else begin segs_nxt = 6'd1; ph_nxt = asfp_pkg::PH_STREAM; end
              end
              asfp_pkg::PH_OBJ:  begin obj_nxt = v; go_offs = 1'b1; end
              asfp_pkg::PH_OFFS: begin ofs_nxt = v; go_rlen = 1'b1; end
              asfp_pkg::PH_RLEN: begin rlen_nxt = v; go_rep = 1'b1; end
              asfp_pkg::PH_REP_TIME: begin
                rtime_nxt = v; skip_nxt = rlen_r - 32'd8;
                if (skip_nxt == 32'd0) go_len = 1'b1;
                else ph_nxt = asfp_pkg::PH_REP_SKIP;
              end
              default: begin len = {2'b00, v}; go_begin = 1'b1; end
            endcase
          end
        end
      endcase
      // header chain
      if (go_seq) begin
        if (lflags_r[2:1] != 2'd0) begin
          ph_nxt = asfp_pkg::PH_SEQ; fleft_nxt = asfp_pkg::code_width(lflags_r[2:1]);
          acc_nxt = '0;
        end else go_pad = 1'b1;
      end
      if (go_pad) begin
        if (lflags_r[4:3] != 2'd0) begin
          ph_nxt = asfp_pkg::PH_PAD; fleft_nxt = asfp_pkg::code_width(lflags_r[4:3]);
          acc_nxt = '0;
        end else begin pad_nxt = '0; go_afterpad = 1'b1; end
      end
      if (go_afterpad) begin
        if (lflags_r[6:5] == 2'd0) plen_nxt = {16'd0, psize_r} - pad_nxt;
        ph_nxt = asfp_pkg::PH_TIME; fleft_nxt = 3'd4; acc_nxt = '0;
      end
      // payload header chain
      if (go_obj) begin
        if (segt_r[5:4] != 2'd0) begin
          ph_nxt = asfp_pkg::PH_OBJ; fleft_nxt = asfp_pkg::code_width(segt_r[5:4]);
          acc_nxt = '0;
        end else begin obj_nxt = '0; go_offs = 1'b1; end
      end
      if (go_offs) begin
        if (segt_r[3:2] != 2'd0) begin
          ph_nxt = asfp_pkg::PH_OFFS; fleft_nxt = asfp_pkg::code_width(segt_r[3:2]);
          acc_nxt = '0;
        end else begin ofs_nxt = '0; go_rlen = 1'b1; end
      end
      if (go_rlen) begin
        if (segt_r[1:0] != 2'd0) begin
          ph_nxt = asfp_pkg::PH_RLEN; fleft_nxt = asfp_pkg::code_width(segt_r[1:0]);
          acc_nxt = '0;
        end else begin rlen_nxt = '0; go_rep = 1'b1; end
      end
      if (go_rep) begin
        rtime_nxt = '0;
        if (rlen_nxt == 32'd1) begin
          skip_nxt = 32'd1; ph_nxt = asfp_pkg::PH_REP_SKIP;
        end else if (rlen_nxt >= 32'd8) begin
          skip_nxt = 32'd4; ph_nxt = asfp_pkg::PH_REP_SIZE;
        end else if (rlen_nxt == 32'd0) go_len = 1'b1;
        else begin skip_nxt = rlen_nxt; ph_nxt = asfp_pkg::PH_REP_SKIP; end
      end
      if (go_len) begin
        if (lflags_r[0] && stype_r != 2'd0) begin
          ph_nxt = asfp_pkg::PH_LEN; fleft_nxt = asfp_pkg::code_width(stype_r);
          acc_nxt = '0;
        end else begin
          len = {{2{plen_r[31]}}, plen_r} - {18'd0, cnt_nxt}; go_begin = 1'b1;
        end
      end
      if (go_begin) begin
        if (len < 0) begin len = '0; err = 1'b1; end
        if (len > {18'd0, rem16}) begin len = {18'd0, rem16}; err = 1'b1; end
        pleft_nxt = len[31:0];
        if (rlen_nxt == 32'd1) begin
          gerr_nxt = err; go_aftergrp = 1'b1;
        end else begin
          cerr_nxt = err; firstp_nxt = 1'b1;
          if (pleft_nxt == 32'd0) go_endseg = 1'b1;
          else ph_nxt = asfp_pkg::PH_DATA;
        end
      end
      if (go_aftergrp) begin
        if (pleft_nxt != 32'd0) ph_nxt = asfp_pkg::PH_GLEN;
        else go_endseg = 1'b1;
      end
      if (go_endseg) begin
        segs_nxt = segs_r - 6'd1;
        ph_nxt = (segs_nxt == 6'd0) ? asfp_pkg::PH_TAIL : asfp_pkg::PH_STREAM;
      end
      if (cnt_nxt >= psize_r) begin
        ph_nxt = asfp_pkg::PH_ECC; cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= asfp_pkg::PH_ECC; psize_r <= asfp_pkg::PacketSizeReset; cnt_r <= '0;
      acc_r <= '0; fleft_r <= '0; lflags_r <= '0; segt_r <= '0; stream_r <= '0;
      gleft_r <= '0; stype_r <= 2'd2; segs_r <= 6'd1; plen_r <= '0; pad_r <= '0;
      obj_r <= '0; ofs_r <= '0; rlen_r <= '0; rtime_r <= '0; skip_r <= '0;
      pleft_r <= '0; dur_r <= '0; firstp_r <= 1'b0; gerr_r <= 1'b0; cerr_r <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      ph_r <= ph_nxt; psize_r <= psize_nxt; cnt_r <= cnt_nxt; acc_r <= acc_nxt;
      fleft_r <= fleft_nxt; lflags_r <= lflags_nxt; segt_r <= segt_nxt;
      stream_r <= stream_nxt; gleft_r <= gleft_nxt; stype_r <= stype_nxt;
      segs_r <= segs_nxt; plen_r <= plen_nxt; pad_r <= pad_nxt; obj_r <= obj_nxt;
      ofs_r <= ofs_nxt; rlen_r <= rlen_nxt; rtime_r <= rtime_nxt; skip_r <= skip_nxt;
      pleft_r <= pleft_nxt; dur_r <= dur_nxt; firstp_r <= firstp_nxt;
      gerr_r <= gerr_nxt; cerr_r <= cerr_nxt; res_valid <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_nxt;
  end

endmodule

// ===== design/asf_data_packet_parser.sv =====
// Top level: streaming byte parser for data packets with an output skid buffer.
// Usage: raw bytes of the data section enter on the in_ channel, one per beat.
// Every payload byte leaves on the out_ channel tagged with its payload header
// fields; header, padding and tail bytes produce no beat.
// Packet length comes from cfg_wr_data when cfg_wr_en is high (reset 4096);
// write it only while the block is idle.
// A payload byte passes through the core's result register and then a skid
// buffer entry before it appears on out_.
// Throughput: one byte per cycle while in_tready is high; the parser core does
// each byte's work combinationally between its input and its result register.
// A two-entry skid buffer after the core holds results while the receiver
// stalls; in_tready drops when the buffered results plus the one in flight
// from the core would overflow it and no beat leaves in that cycle.
// Reset (rst_n low, synchronous) returns the parser to the start of a packet,
// packet length 4096, and empties the output buffer.
// When the receiver stalls, results are held in order; nothing is dropped.
module asf_data_packet_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // payload_byte, stream_number, keyframe, object_number, fragment_offset,
  // presentation_time, duration, grouped, first_byte, last_byte, length_error
  output logic [135:0] out_tdata
);

  logic              rv;
  asfp_pkg::result_t res;
  asfp_pkg::result_t q_r [2];
  logic [1:0]        cnt_r;
  logic              rd_r, wr_r;
  logic              pop;

  asfp_parse_core u_core (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .byte_valid(in_tvalid && in_tready), .byte_data(in_tdata),
    .res_valid(rv), .res
  );

  assign in_tready  = ({1'b0, cnt_r} + {2'b00, rv}) <= (3'd1 + {2'b00, pop});
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      if (rv) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, rv} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (rv) q_r[wr_r] <= res;
  end

  always_comb begin
    asfp_pkg::result_t h;
    h = q_r[rd_r];
    out_tdata = {3'd0, h.length_error, h.last_byte, h.first_byte, h.grouped,
                 h.duration, h.presentation_time, h.fragment_offset,
                 h.object_number, h.keyframe, h.stream_number, h.payload_byte};
  end

endmodule

// ===== design/asfp_checker.sv =====
// Port checker for the data packet parser, bound to the top level.
module asfp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out_tvalid dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("out_tdata changed");

  a_no_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) ##1 !out_tvalid |=> !out_tvalid)
    else $error("result without input beat");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("stalled while empty");

endmodule

bind asf_data_packet_parser asfp_checker u_asfp_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
